// File: sv/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, register map, reset values and interface types of the
// bit-serial PID rate controller.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Fixed point and state widths
  localparam int unsigned GAIN_FRAC_BITS = 8;
  localparam int unsigned INTEG_WIDTH    = 40;
  localparam int unsigned DATA_W         = 16;
  // error = set_point - frame_count * rate_scale
  localparam int unsigned ERR_W          = 2 * DATA_W + 1;
  // integrator plus error before saturation
  localparam int unsigned SUM_W          = INTEG_WIDTH + 1;
  // multiplier operand: a 16 bit gain sign or zero extended
  localparam int unsigned GM_W           = DATA_W + 1;
  // width that holds the whole weighted sum without wrapping
  localparam int unsigned ACC_W          = INTEG_WIDTH + DATA_W + 2;
  localparam int unsigned CNT_W          = $clog2(ACC_W);

  // Register map
  localparam int unsigned NUM_REGS       = 6;
  localparam int unsigned REG_IDX_W      = $clog2(NUM_REGS);
  localparam int unsigned ADDR_W         = REG_IDX_W + 2;
  localparam int unsigned APB_DATA_W     = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SET_POINT  = 3'd0,
    REG_RATE_SCALE = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_GAIN_D     = 3'd4,
    REG_CTL_LIMIT  = 3'd5
  } prc_reg_e;

  localparam logic [DATA_W-1:0] SET_POINT_RST  = 16'd40;
  localparam logic [DATA_W-1:0] RATE_SCALE_RST = 16'd1;
  localparam logic [DATA_W-1:0] GAIN_P_RST     = 16'hFFCD; // -51, about -0.2
  localparam logic [DATA_W-1:0] GAIN_I_RST     = 16'hFF80; // -128, -0.5
  localparam logic [DATA_W-1:0] GAIN_D_RST     = 16'h0000;
  localparam logic [DATA_W-1:0] CTL_LIMIT_RST  = 16'd500;

  typedef struct packed {
    logic [DATA_W-1:0] set_point;
    logic [DATA_W-1:0] rate_scale;
    logic [DATA_W-1:0] gain_p;
    logic [DATA_W-1:0] gain_i;
    logic [DATA_W-1:0] gain_d;
    logic [DATA_W-1:0] ctl_limit;
  } prc_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] control_value;
    logic              integ_saturated;
  } prc_res_t;

endpackage

// File: sv/prc_sermul.sv
// ----------------------------------------------------------------------------
// prc_sermul
// Serial-parallel multiplier: multiplicand enters one bit a cycle, LSB
// first, against a parallel two's complement operand; product leaves LSB
// first.
// ----------------------------------------------------------------------------
module prc_sermul (
  input  logic                       clk_i,
  input  logic                       clr_i,
  input  logic                       en_i,
  input  logic                       x_i,
  input  logic [prc_pkg::GM_W-1:0]   g_i,
  output logic                       bit_o
);
  import prc_pkg::*;

  logic [GM_W-1:0] part_q;
  logic [GM_W-1:0] part_d;
  logic [GM_W:0]   full;

  // add the operand when the incoming bit is set, emit the LSB, halve the rest
  always_comb begin
    full   = {part_q[GM_W-1], part_q} + (x_i ? {g_i[GM_W-1], g_i} : '0);
    bit_o  = full[0];
    part_d = full[GM_W:1];
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      part_q <= '0;
    end else if (en_i) begin
      part_q <= part_d;
    end
  end

endmodule

// File: sv/prc_core.sv
// ----------------------------------------------------------------------------
// prc_core
// Bit-serial PID datapath and its sequencer: error and integrator pass,
// then weighted-sum pass with serial clamp compare.
// ----------------------------------------------------------------------------
module prc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prc_pkg::prc_cfg_t           cfg_i,
  input  logic                        start_i,
  input  logic [prc_pkg::DATA_W-1:0]  frame_count_i,
  output logic                        idle_o,
  output prc_pkg::prc_res_t           res_o,
  input  logic                        res_ready_i
);
  import prc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_MIX,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [INTEG_WIDTH-1:0] integ_q;
  logic [ERR_W-1:0]       prev_q;
  logic [DATA_W-1:0]      ctl_q;
  logic                   sat_q;

  // serial operand registers
  logic [DATA_W-1:0]      fc_q;
  logic [DATA_W-1:0]      sp_q;
  logic [ERR_W-1:0]       err_q;
  logic [ERR_W-1:0]       ea_q;
  logic [ERR_W-1:0]       pa_q;
  logic [INTEG_WIDTH-1:0] ia_q;
  logic [SUM_W-1:0]       sum_q;
  logic [DATA_W-1:0]      smax_q;
  logic [DATA_W-1:0]      ql_q;
  logic                   bor_q;
  logic                   cy_q;
  logic                   dbor_q;
  logic [1:0]             acy_q;
  logic                   gt_q;

  logic                   err_last;
  logic                   mix_last;
  logic                   in_err;
  logic                   in_mix;
  logic                   mul_clr_rate;
  logic                   mul_clr_mix;

  logic                   rate_bit;
  logic                   e_bit;
  logic                   bor_d;
  logic [1:0]             s2;
  logic [SUM_W-1:0]       sum_full;
  logic                   sat_hit;
  logic [INTEG_WIDTH-1:0] sat_val;

  logic                   d_bit;
  logic                   dbor_d;
  logic                   mp_bit;
  logic                   mi_bit;
  logic                   md_bit;
  logic [2:0]             a3;
  logic                   acc_bit;
  logic                   gt_d;
  logic [DATA_W-1:0]      ctl_d;

  assign in_err       = (state_q == ST_ERR);
  assign in_mix       = (state_q == ST_MIX);
  assign err_last     = in_err && (cnt_q == CNT_W'(SUM_W - 1));
  assign mix_last     = in_mix && (cnt_q == CNT_W'(ACC_W - 1));
  assign mul_clr_rate = (state_q == ST_IDLE) && start_i;
  assign mul_clr_mix  = err_last;

  // rate = frame_count * rate_scale, unsigned
  prc_sermul u_mul_rate (
    .clk_i (clk_i),
    .clr_i (mul_clr_rate),
    .en_i  (in_err),
    .x_i   (fc_q[0]),
    .g_i   ({1'b0, cfg_i.rate_scale}),
    .bit_o (rate_bit)
  );

  // error, integrator sum and saturation
  always_comb begin
    e_bit    = sp_q[0] ^ rate_bit ^ bor_q;
    bor_d    = (~sp_q[0] & rate_bit) | (~sp_q[0] & bor_q) | (rate_bit & bor_q);
    s2       = {1'b0, ia_q[0]} + {1'b0, e_bit} + {1'b0, cy_q};
    sum_full = {s2[0], sum_q[SUM_W-1:1]};
    sat_hit  = sum_full[SUM_W-1] != sum_full[SUM_W-2];
    if (!sat_hit) begin
      sat_val = sum_full[INTEG_WIDTH-1:0];
    end else if (sum_full[SUM_W-1]) begin
      sat_val = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
    end
  end

  // diff = error - previous error
  always_comb begin
    d_bit  = ea_q[0] ^ pa_q[0] ^ dbor_q;
    dbor_d = (~ea_q[0] & pa_q[0]) | (~ea_q[0] & dbor_q) | (pa_q[0] & dbor_q);
  end

  prc_sermul u_mul_p (
    .clk_i (clk_i),
    .clr_i (mul_clr_mix),
    .en_i  (in_mix),
    .x_i   (ea_q[0]),
    .g_i   ({cfg_i.gain_p[DATA_W-1], cfg_i.gain_p}),
    .bit_o (mp_bit)
  );

  prc_sermul u_mul_i (
    .clk_i (clk_i),
    .clr_i (mul_clr_mix),
    .en_i  (in_mix),
    .x_i   (ia_q[0]),
    .g_i   ({cfg_i.gain_i[DATA_W-1], cfg_i.gain_i}),
    .bit_o (mi_bit)
  );

  prc_sermul u_mul_d (
    .clk_i (clk_i),
    .clr_i (mul_clr_mix),
    .en_i  (in_mix),
    .x_i   (d_bit),
    .g_i   ({cfg_i.gain_d[DATA_W-1], cfg_i.gain_d}),
    .bit_o (md_bit)
  );

  // three-way serial add, then compare the quotient bits with ctl_limit
  always_comb begin
    a3      = {2'b00, mp_bit} + {2'b00, mi_bit} + {2'b00, md_bit} + {1'b0, acy_q};
    acc_bit = a3[0];
    gt_d    = (acc_bit & ~smax_q[0]) | (~(acc_bit ^ smax_q[0]) & gt_q);
    // the last bit is the sign: negative sums drive zero
    if (acc_bit) begin
      ctl_d = '0;
    end else if (gt_d) begin
      ctl_d = cfg_i.ctl_limit;
    end else begin
      ctl_d = ql_q;
    end
  end

  // operand shift registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        fc_q  <= frame_count_i;
        sp_q  <= cfg_i.set_point;
        ia_q  <= integ_q;
        bor_q <= 1'b0;
        cy_q  <= 1'b0;
      end
      ST_ERR: begin
        fc_q  <= {1'b0, fc_q[DATA_W-1:1]};
        sp_q  <= {1'b0, sp_q[DATA_W-1:1]};
        bor_q <= bor_d;
        cy_q  <= s2[1];
        sum_q <= sum_full;
        if (cnt_q < CNT_W'(ERR_W)) begin
          err_q <= {e_bit, err_q[ERR_W-1:1]};
        end
        if (err_last) begin
          ia_q   <= sat_val;
          ea_q   <= err_q;
          pa_q   <= prev_q;
          smax_q <= cfg_i.ctl_limit;
          dbor_q <= 1'b0;
          acy_q  <= 2'b00;
          gt_q   <= 1'b0;
        end else begin
          ia_q <= {ia_q[INTEG_WIDTH-1], ia_q[INTEG_WIDTH-1:1]};
        end
      end
      ST_MIX: begin
        ea_q   <= {ea_q[ERR_W-1], ea_q[ERR_W-1:1]};
        pa_q   <= {pa_q[ERR_W-1], pa_q[ERR_W-1:1]};
        ia_q   <= {ia_q[INTEG_WIDTH-1], ia_q[INTEG_WIDTH-1:1]};
        dbor_q <= dbor_d;
        acy_q  <= a3[2:1];
        if (cnt_q >= CNT_W'(GAIN_FRAC_BITS)) begin
          smax_q <= {1'b0, smax_q[DATA_W-1:1]};
          gt_q   <= gt_d;
          if (cnt_q < CNT_W'(GAIN_FRAC_BITS + DATA_W)) begin
            ql_q <= {acc_bit, ql_q[DATA_W-1:1]};
          end
        end
      end
      ST_DONE: begin
        fc_q <= fc_q;
      end
      default: begin
        fc_q <= fc_q;
      end
    endcase
  end

  // sequencer, controller state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      integ_q <= '0;
      prev_q  <= '0;
      ctl_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (start_i) begin
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          if (err_last) begin
            cnt_q   <= '0;
            integ_q <= sat_val;
            sat_q   <= sat_hit;
            prev_q  <= err_q;
            state_q <= ST_MIX;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MIX: begin
          if (mix_last) begin
            ctl_q   <= ctl_d;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle_o                = (state_q == ST_IDLE);
  assign res_o.valid           = (state_q == ST_DONE);
  assign res_o.control_value   = ctl_q;
  assign res_o.integ_saturated = sat_q;

endmodule

// File: sv/pid_rate_controller.sv
// ----------------------------------------------------------------------------
// pid_rate_controller
// Discrete PID controller with output clamp: one frame count in, one
// clamped control value and an integrator saturation flag out.
// ----------------------------------------------------------------------------
// One item goes through the bit-serial error and integrator pass over the
// 41 bit unsaturated integrator sum, then the bit-serial weighted sum of the
// three gain products over the 58 bit exact accumulator, then the hand-over
// of the result to the output register, which waits while that register is
// full and not being emptied. A new item is taken only once the core is idle
// again after the hand-over. All arithmetic runs one bit a cycle through
// shift registers and 17 bit serial-parallel multipliers. The output
// register holds a finished result while the next item is being worked on.
// Registers sit on an APB port at byte addresses 0x00 to 0x14 in this order:
// set_point, rate_scale, gain_p, gain_i, gain_d, ctl_limit; write them only
// while no item is in flight. Gains are signed Q8.8.
// ----------------------------------------------------------------------------
module pid_rate_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]       paddr,
  input  logic [prc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [prc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [prc_pkg::DATA_W-1:0]       s_axis_tdata,  // [15:0] frame_count
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [prc_pkg::DATA_W-1:0]       m_axis_tdata,  // [15:0] control_value
  output logic [0:0]                       m_axis_tuser   // [0] integ_saturated
);
  import prc_pkg::*;

  prc_cfg_t              cfg_q;
  prc_res_t              res;
  logic                  core_idle;
  logic                  res_ready;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [DATA_W-1:0]     rd_val;
  logic                  m_valid_q;
  logic [DATA_W-1:0]     m_data_q;
  logic                  m_user_q;

  // --------------------------------------------------------------------------
  // Configuration registers: write in the access phase, read back as written
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_point  <= SET_POINT_RST;
      cfg_q.rate_scale <= RATE_SCALE_RST;
      cfg_q.gain_p     <= GAIN_P_RST;
      cfg_q.gain_i     <= GAIN_I_RST;
      cfg_q.gain_d     <= GAIN_D_RST;
      cfg_q.ctl_limit  <= CTL_LIMIT_RST;
    end else if (wr_en) begin
      // drop writes beyond the register list
      unique case (reg_idx)
        REG_SET_POINT:  cfg_q.set_point  <= pwdata[DATA_W-1:0];
        REG_RATE_SCALE: cfg_q.rate_scale <= pwdata[DATA_W-1:0];
        REG_GAIN_P:     cfg_q.gain_p     <= pwdata[DATA_W-1:0];
        REG_GAIN_I:     cfg_q.gain_i     <= pwdata[DATA_W-1:0];
        REG_GAIN_D:     cfg_q.gain_d     <= pwdata[DATA_W-1:0];
        REG_CTL_LIMIT:  cfg_q.ctl_limit  <= pwdata[DATA_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SET_POINT:  rd_val = cfg_q.set_point;
      REG_RATE_SCALE: rd_val = cfg_q.rate_scale;
      REG_GAIN_P:     rd_val = cfg_q.gain_p;
      REG_GAIN_I:     rd_val = cfg_q.gain_i;
      REG_GAIN_D:     rd_val = cfg_q.gain_d;
      REG_CTL_LIMIT:  rd_val = cfg_q.ctl_limit;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_W-DATA_W){1'b0}}, rd_val};

  // --------------------------------------------------------------------------
  // Serial core: take an item whenever it is idle
  // --------------------------------------------------------------------------
  assign s_axis_tready = core_idle;

  prc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .start_i       (s_axis_tvalid),
    .frame_count_i (s_axis_tdata),
    .idle_o        (core_idle),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // --------------------------------------------------------------------------
  // Output register: free when empty or being emptied this cycle
  // --------------------------------------------------------------------------
  assign res_ready = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      m_data_q <= res.control_value;
      m_user_q <= res.integ_saturated;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_item_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is still in flight");

  a_output_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= cfg_q.ctl_limit)
    else $error("control value above ctl_limit");

  a_handover_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res_ready |=> m_axis_tvalid && $past(core_idle) == 1'b0)
    else $error("core result not taken into the output register");

endmodule
